FILE: rtl/dual_pid_drive_controller_macros.svh
// Assertion macros shared by the drive controller RTL
`ifndef DUAL_PID_DRIVE_CONTROLLER_MACROS_SVH
`define DUAL_PID_DRIVE_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// cond must hold at every clock edge out of reset
`define DPDC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dpdc: invariant violated");
// cons must hold in the same cycle as ante
`define DPDC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpdc: same-cycle implication violated");
// cons must hold in the cycle after ante
`define DPDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpdc: next-cycle implication violated");
`else
`define DPDC_ASSERT_ALWAYS(label, cond)
`define DPDC_ASSERT_IMPLIES(label, ante, cons)
`define DPDC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/dpdc_pkg.sv
// Types, constants, microcode and saturation helpers for the drive controller
package dpdc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_TARGET_DIST = 3'd0;
    localparam logic [2:0] REG_TARGET_HEAD = 3'd1;
    localparam logic [2:0] REG_DIST_KP     = 3'd2;
    localparam logic [2:0] REG_DIST_KI     = 3'd3;
    localparam logic [2:0] REG_DIST_KD     = 3'd4;
    localparam logic [2:0] REG_HEAD_KP     = 3'd5;
    localparam logic [2:0] REG_HEAD_KI     = 3'd6;
    localparam logic [2:0] REG_HEAD_KD     = 3'd7;

    // Gain reset values, 16 fractional bits
    localparam logic [15:0] DIST_KP_RST = 16'd786;
    localparam logic [15:0] DIST_KI_RST = 16'd131;
    localparam logic [15:0] DIST_KD_RST = 16'd786;
    localparam logic [15:0] HEAD_KP_RST = 16'd1966;
    localparam logic [15:0] HEAD_KI_RST = 16'd1311;
    localparam logic [15:0] HEAD_KD_RST = 16'd655;

    // cm per degree of wheel rotation, Q0.32
    localparam logic signed [29:0] CM_PER_DEG = 30'sd511704715;
    // Rounding bias for the >>33 of the position product
    localparam logic signed [63:0] POS_ROUND  = 64'sh0000_0001_0000_0000;
    // Stop tolerance: error magnitude must exceed this (0.3 cm)
    localparam logic signed [31:0] TOL        = 32'sd19660;
    // Correction margin, 3 degrees
    localparam logic signed [31:0] MARGIN     = 32'sd196608;
    // Drive limit, 12 V
    localparam logic signed [20:0] VMAX       = 21'sd786432;

    typedef logic [3:0] step_t;

    // Program step addresses
    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_POS      = 4'd1;
    localparam step_t STEP_HERR_KP  = 4'd2;
    localparam step_t STEP_HDER_KD  = 4'd3;
    localparam step_t STEP_HSUM_LO  = 4'd4;
    localparam step_t STEP_HSUM_HI  = 4'd5;
    localparam step_t STEP_DERR_KP  = 4'd6;
    localparam step_t STEP_DDER_KD  = 4'd7;
    localparam step_t STEP_DSUM_LO  = 4'd8;
    localparam step_t STEP_DSUM_HI  = 4'd9;
    localparam step_t STEP_DSUM_ACC = 4'd10;
    localparam step_t STEP_EMIT     = 4'd11;

    typedef enum logic [1:0] {
        CORR_NONE = 2'd0,
        CORR_CCW  = 2'd1,
        CORR_CW   = 2'd2
    } corr_t;

    typedef enum logic [3:0] {
        A_LRSUM,
        A_HERR,
        A_HDER,
        A_HSUM_LO,
        A_HSUM_HI,
        A_DERR,
        A_DDER,
        A_DSUM_LO,
        A_DSUM_HI
    } a_sel_t;

    typedef enum logic [2:0] {
        B_CM,
        B_HKP,
        B_HKD,
        B_HKI,
        B_DKP,
        B_DKD,
        B_DKI
    } b_sel_t;

    typedef enum logic [1:0] {
        P_HOLD,
        P_LOAD,
        P_ADD_HI
    } p_op_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_TURN,
        ACC_LAT
    } acc_op_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_WAIT_OUT
    } jump_t;

    // One control word of the program
    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        p_op_t   p_op;
        acc_op_t acc_op;
        logic    upd_derr;
        logic    upd_head;
        logic    upd_dist;
        logic    emit;
        jump_t   jump;
        step_t   target;
    } ctrl_t;

    // Sequencer status inputs
    typedef struct packed {
        logic start;
        logic run;
        logic hold;
    } seq_in_t;

    // Program ROM
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t c;
        c.a_sel    = A_LRSUM;
        c.b_sel    = B_CM;
        c.p_op     = P_HOLD;
        c.acc_op   = ACC_NONE;
        c.upd_derr = 1'b0;
        c.upd_head = 1'b0;
        c.upd_dist = 1'b0;
        c.emit     = 1'b0;
        c.jump     = J_NEXT;
        c.target   = STEP_IDLE;
        unique case (step)
            STEP_IDLE: begin
                c.jump = J_DISPATCH;
            end
            STEP_POS: begin
                c.a_sel = A_LRSUM;
                c.b_sel = B_CM;
                c.p_op  = P_LOAD;
            end
            STEP_HERR_KP: begin
                c.a_sel    = A_HERR;
                c.b_sel    = B_HKP;
                c.p_op     = P_LOAD;
                c.upd_derr = 1'b1;
                c.upd_head = 1'b1;
            end
            STEP_HDER_KD: begin
                c.a_sel    = A_HDER;
                c.b_sel    = B_HKD;
                c.p_op     = P_LOAD;
                c.acc_op   = ACC_TURN;
                c.upd_dist = 1'b1;
            end
            STEP_HSUM_LO: begin
                c.a_sel  = A_HSUM_LO;
                c.b_sel  = B_HKI;
                c.p_op   = P_LOAD;
                c.acc_op = ACC_TURN;
            end
            STEP_HSUM_HI: begin
                c.a_sel = A_HSUM_HI;
                c.b_sel = B_HKI;
                c.p_op  = P_ADD_HI;
            end
            STEP_DERR_KP: begin
                c.a_sel  = A_DERR;
                c.b_sel  = B_DKP;
                c.p_op   = P_LOAD;
                c.acc_op = ACC_TURN;
            end
            STEP_DDER_KD: begin
                c.a_sel  = A_DDER;
                c.b_sel  = B_DKD;
                c.p_op   = P_LOAD;
                c.acc_op = ACC_LAT;
            end
            STEP_DSUM_LO: begin
                c.a_sel  = A_DSUM_LO;
                c.b_sel  = B_DKI;
                c.p_op   = P_LOAD;
                c.acc_op = ACC_LAT;
            end
            STEP_DSUM_HI: begin
                c.a_sel = A_DSUM_HI;
                c.b_sel = B_DKI;
                c.p_op  = P_ADD_HI;
            end
            STEP_DSUM_ACC: begin
                c.acc_op = ACC_LAT;
            end
            STEP_EMIT: begin
                c.emit   = 1'b1;
                c.jump   = J_WAIT_OUT;
                c.target = STEP_IDLE;
            end
            default: begin
                c.jump   = J_GOTO;
                c.target = STEP_IDLE;
            end
        endcase
        return c;
    endfunction

    // Saturate 33-bit signed to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
        logic signed [31:0] r;
        if (x[32] != x[31]) begin
            r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Saturate 49-bit signed to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
        logic signed [47:0] r;
        if (x[48] != x[47]) begin
            r = x[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        end else begin
            r = x[47:0];
        end
        return r;
    endfunction

    // Clamp a drive sum to +/-12 V
    function automatic logic signed [20:0] sat_drive(input logic signed [50:0] x);
        logic signed [20:0] r;
        if (x > 51'(VMAX)) begin
            r = VMAX;
        end else if (x < -51'(VMAX)) begin
            r = -VMAX;
        end else begin
            r = x[20:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/dpdc_seq.sv
// Microcode sequencer: step counter, program ROM and jump logic
module dpdc_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  dpdc_pkg::seq_in_t stat,
    output dpdc_pkg::ctrl_t   ctrl,
    output logic              idle
);

    dpdc_pkg::step_t step_reg;
    dpdc_pkg::step_t step_next;

    // Control word of the current step
    assign ctrl = dpdc_pkg::ucode(step_reg);
    assign idle = (step_reg == dpdc_pkg::STEP_IDLE);

    // Next step address
    always_comb
    begin
        step_next = step_reg;
        unique case (ctrl.jump)
            dpdc_pkg::J_NEXT: begin
                step_next = step_reg + 4'd1;
            end
            dpdc_pkg::J_GOTO: begin
                step_next = ctrl.target;
            end
            dpdc_pkg::J_DISPATCH: begin
                // running ticks enter the program, finished ticks go to emit
                if (stat.start) begin
                    step_next = stat.run ? dpdc_pkg::STEP_POS : dpdc_pkg::STEP_EMIT;
                end
            end
            dpdc_pkg::J_WAIT_OUT: begin
                if (!stat.hold) begin
                    step_next = ctrl.target;
                end
            end
            default: begin
                step_next = dpdc_pkg::STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg <= dpdc_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: rtl/dual_pid_drive_controller.sv
// Dual PID drive controller: one result word per accepted tick word.
// A running tick goes through the full program; a finished tick goes straight to the emit step.
// One tick word at a time: a new word is taken only once the sequencer is back in idle,
// as the one shared 34x30 multiplier is stepped by the microcode through seven products.
// A stalled result holds the next one in the emit step, and no new word is taken meanwhile.
// Reset (rst_n, async): registers to defaults, loop state cleared, no result pending.
`include "dual_pid_drive_controller_macros.svh"

module dual_pid_drive_controller (
    input  logic               clk,
    input  logic               rst_n,
    // tick word in
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,
    input  logic signed [31:0] left_angle,
    input  logic signed [31:0] right_angle,
    input  logic signed [31:0] heading,
    // result word out
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [20:0] left_drive,
    output logic signed [20:0] right_drive,
    output logic               done_res,
    output logic [1:0]         correction,
    // register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // Configuration registers
    logic signed [31:0] target_dist_reg;
    logic signed [31:0] target_head_reg;
    logic [15:0]        dist_kp_reg;
    logic [15:0]        dist_ki_reg;
    logic [15:0]        dist_kd_reg;
    logic [15:0]        head_kp_reg;
    logic [15:0]        head_ki_reg;
    logic [15:0]        head_kd_reg;

    // Loop state
    logic signed [31:0] check_err_reg;
    logic signed [31:0] prev_derr_reg;
    logic signed [47:0] dsum_reg;
    logic signed [31:0] prev_herr_reg;
    logic signed [47:0] hsum_reg;
    logic               finished_reg;

    // Working registers
    logic signed [32:0] lrsum_reg;
    logic signed [31:0] herr_reg;
    logic signed [32:0] hder_reg;
    logic signed [31:0] derr_reg;
    logic signed [32:0] dder_reg;
    logic signed [63:0] prod_reg;
    logic signed [49:0] turn_reg;
    logic signed [49:0] lat_reg;
    logic               fin_tick_reg;
    dpdc_pkg::corr_t    corr_reg;

    // Output register
    logic               out_valid_reg;
    logic signed [20:0] left_drive_reg;
    logic signed [20:0] right_drive_reg;
    logic               done_reg;
    dpdc_pkg::corr_t    corr_out_reg;

    dpdc_pkg::ctrl_t    ctrl;
    dpdc_pkg::seq_in_t  seq_stat;
    logic               seq_idle;
    logic               in_accept;
    logic               out_hold;

    // Accept-time decision
    logic signed [31:0] chk_eff;
    logic               fin_eff;
    logic               running;
    dpdc_pkg::corr_t    corr_now;
    logic signed [31:0] herr_now;

    // Datapath
    logic signed [33:0] a_op;
    logic signed [29:0] b_op;
    logic signed [63:0] mul;
    logic signed [63:0] pos_sum;
    logic signed [30:0] pos;
    logic signed [31:0] derr_now;
    logic signed [47:0] prod_term;
    logic signed [50:0] lat_minus;
    logic signed [50:0] lat_plus;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = !seq_idle;
    assign in_accept = in_valid && !in_stall;
    assign out_hold  = out_valid_reg && out_stall;

    assign seq_stat.start = in_accept;
    assign seq_stat.run   = running;
    assign seq_stat.hold  = out_hold;

    dpdc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (seq_stat),
        .ctrl  (ctrl),
        .idle  (seq_idle)
    );

    // Continue test on the error left by the last tick (after any restart)
    assign chk_eff = restart ? target_dist_reg : check_err_reg;
    assign fin_eff = restart ? 1'b0 : finished_reg;
    assign running = !fin_eff &&
                     ((chk_eff > dpdc_pkg::TOL && target_dist_reg > 32'sd0) ||
                      (chk_eff < -dpdc_pkg::TOL && target_dist_reg < 32'sd0));

    // Correction direction from this tick's heading
    always_comb
    begin
        priority if (heading > dpdc_pkg::MARGIN) begin
            corr_now = dpdc_pkg::CORR_CCW;
        end else if (heading < -dpdc_pkg::MARGIN) begin
            corr_now = dpdc_pkg::CORR_CW;
        end else begin
            corr_now = dpdc_pkg::CORR_NONE;
        end
    end

    assign herr_now = dpdc_pkg::sat32(33'(heading) - 33'(target_head_reg));

    // Multiplier operand A
    always_comb
    begin
        unique case (ctrl.a_sel)
            dpdc_pkg::A_LRSUM:   a_op = 34'(lrsum_reg);
            dpdc_pkg::A_HERR:    a_op = 34'(herr_reg);
            dpdc_pkg::A_HDER:    a_op = 34'(hder_reg);
            dpdc_pkg::A_HSUM_LO: a_op = {10'd0, hsum_reg[23:0]};
            dpdc_pkg::A_HSUM_HI: a_op = 34'($signed(hsum_reg[47:24]));
            dpdc_pkg::A_DERR:    a_op = 34'(derr_reg);
            dpdc_pkg::A_DDER:    a_op = 34'(dder_reg);
            dpdc_pkg::A_DSUM_LO: a_op = {10'd0, dsum_reg[23:0]};
            dpdc_pkg::A_DSUM_HI: a_op = 34'($signed(dsum_reg[47:24]));
            default:             a_op = 34'sd0;
        endcase
    end

    // Multiplier operand B
    always_comb
    begin
        unique case (ctrl.b_sel)
            dpdc_pkg::B_CM:  b_op = dpdc_pkg::CM_PER_DEG;
            dpdc_pkg::B_HKP: b_op = {14'd0, head_kp_reg};
            dpdc_pkg::B_HKD: b_op = {14'd0, head_kd_reg};
            dpdc_pkg::B_HKI: b_op = {14'd0, head_ki_reg};
            dpdc_pkg::B_DKP: b_op = {14'd0, dist_kp_reg};
            dpdc_pkg::B_DKD: b_op = {14'd0, dist_kd_reg};
            dpdc_pkg::B_DKI: b_op = {14'd0, dist_ki_reg};
            default:         b_op = 30'sd0;
        endcase
    end

    // Shared multiplier
    assign mul = 64'(a_op) * 64'(b_op);

    // Position in cm, rounded, from the encoder product
    assign pos_sum  = prod_reg + dpdc_pkg::POS_ROUND;
    assign pos      = pos_sum[63:33];
    assign derr_now = dpdc_pkg::sat32(33'(target_dist_reg) - 33'(pos));

    // Product floored by 16 fractional bits
    assign prod_term = prod_reg[63:16];

    assign lat_minus = 51'(lat_reg) - 51'(turn_reg);
    assign lat_plus  = 51'(lat_reg) + 51'(turn_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            target_dist_reg <= 32'sd0;
            target_head_reg <= 32'sd0;
            dist_kp_reg     <= dpdc_pkg::DIST_KP_RST;
            dist_ki_reg     <= dpdc_pkg::DIST_KI_RST;
            dist_kd_reg     <= dpdc_pkg::DIST_KD_RST;
            head_kp_reg     <= dpdc_pkg::HEAD_KP_RST;
            head_ki_reg     <= dpdc_pkg::HEAD_KI_RST;
            head_kd_reg     <= dpdc_pkg::HEAD_KD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dpdc_pkg::REG_TARGET_DIST: target_dist_reg <= cfg_data;
                dpdc_pkg::REG_TARGET_HEAD: target_head_reg <= cfg_data;
                dpdc_pkg::REG_DIST_KP:     dist_kp_reg     <= cfg_data[15:0];
                dpdc_pkg::REG_DIST_KI:     dist_ki_reg     <= cfg_data[15:0];
                dpdc_pkg::REG_DIST_KD:     dist_kd_reg     <= cfg_data[15:0];
                dpdc_pkg::REG_HEAD_KP:     head_kp_reg     <= cfg_data[15:0];
                dpdc_pkg::REG_HEAD_KI:     head_ki_reg     <= cfg_data[15:0];
                dpdc_pkg::REG_HEAD_KD:     head_kd_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Loop state: cleared by restart, updated by the program
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            check_err_reg <= 32'sd0;
            prev_derr_reg <= 32'sd0;
            dsum_reg      <= 48'sd0;
            prev_herr_reg <= 32'sd0;
            hsum_reg      <= 48'sd0;
            finished_reg  <= 1'b0;
        end else if (in_accept) begin
            if (restart) begin
                check_err_reg <= target_dist_reg;
                prev_derr_reg <= 32'sd0;
                dsum_reg      <= 48'sd0;
                prev_herr_reg <= 32'sd0;
                hsum_reg      <= 48'sd0;
                finished_reg  <= 1'b0;
            end
            if (!running) begin
                finished_reg <= 1'b1;
            end
        end else begin
            if (ctrl.upd_head) begin
                hsum_reg      <= dpdc_pkg::sat48(49'(hsum_reg) + 49'(herr_reg));
                prev_herr_reg <= herr_reg;
            end
            if (ctrl.upd_dist) begin
                dsum_reg      <= dpdc_pkg::sat48(49'(dsum_reg) + 49'(derr_reg));
                prev_derr_reg <= derr_reg;
                check_err_reg <= derr_reg;
            end
        end
    end

    // Working datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            lrsum_reg    <= 33'(left_angle) + 33'(right_angle);
            herr_reg     <= herr_now;
            turn_reg     <= 50'sd0;
            lat_reg      <= 50'sd0;
            fin_tick_reg <= !running;
            corr_reg     <= running ? dpdc_pkg::CORR_NONE : corr_now;
        end else begin
            // product register
            unique case (ctrl.p_op)
                dpdc_pkg::P_LOAD:   prod_reg <= mul;
                dpdc_pkg::P_ADD_HI: prod_reg <= prod_reg + {mul[39:0], 24'd0};
                default: ;
            endcase
            // term accumulators
            unique case (ctrl.acc_op)
                dpdc_pkg::ACC_TURN: turn_reg <= turn_reg + 50'(prod_term);
                dpdc_pkg::ACC_LAT:  lat_reg  <= lat_reg + 50'(prod_term);
                default: ;
            endcase
            if (ctrl.upd_derr) begin
                derr_reg <= derr_now;
            end
            if (ctrl.upd_head) begin
                hder_reg <= 33'(herr_reg) - 33'(prev_herr_reg);
            end
            if (ctrl.upd_dist) begin
                dder_reg <= 33'(derr_reg) - 33'(prev_derr_reg);
            end
        end
    end

    // Result word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.emit && !out_hold) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        if (ctrl.emit && !out_hold) begin
            left_drive_reg  <= fin_tick_reg ? 21'sd0 : dpdc_pkg::sat_drive(lat_minus);
            right_drive_reg <= fin_tick_reg ? 21'sd0 : dpdc_pkg::sat_drive(lat_plus);
            done_reg        <= fin_tick_reg;
            corr_out_reg    <= corr_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_drive  = left_drive_reg;
    assign right_drive = right_drive_reg;
    assign done_res    = done_reg;
    assign correction  = corr_out_reg;

    // Checks
    `DPDC_ASSERT_NEXT(a_accept_busy, in_accept, !seq_idle)
    `DPDC_ASSERT_IMPLIES(a_done_zero_drive, out_valid && done_res, left_drive == 21'sd0 && right_drive == 21'sd0)
    `DPDC_ASSERT_IMPLIES(a_corr_with_done, out_valid && correction != dpdc_pkg::CORR_NONE, done_res)
    `DPDC_ASSERT_IMPLIES(a_drive_range, out_valid, left_drive >= -dpdc_pkg::VMAX && left_drive <= dpdc_pkg::VMAX && right_drive >= -dpdc_pkg::VMAX && right_drive <= dpdc_pkg::VMAX)

endmodule

FILE: test/dual_pid_drive_controller_check.sv
// Drive controller checker: tick predictor and result word comparison
module dual_pid_drive_controller_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               restart,
    input  logic signed [31:0] left_angle,
    input  logic signed [31:0] right_angle,
    input  logic signed [31:0] heading,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [20:0] left_drive,
    input  logic signed [20:0] right_drive,
    input  logic               done_res,
    input  logic [1:0]         correction,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fails,
    output int                 pending
);

    // cm per degree of wheel rotation, Q0.32
    localparam longint DEG_TO_CM   = 64'sd511704715;
    localparam longint POS_BIAS    = 64'sd4294967296;
    // 0.3 cm stop band and 3 degree correction margin, Q16.16
    localparam longint STOP_TOL    = 64'sd19660;
    localparam longint CORR_MARGIN = 64'sd196608;
    localparam longint DRIVE_MAX   = 64'sd786432;
    localparam longint ERR_MAX     = 64'sd2147483647;
    localparam longint ERR_MIN     = -64'sd2147483648;
    localparam longint SUM_MAX     = 64'sd140737488355327;
    localparam longint SUM_MIN     = -SUM_MAX - 64'sd1;

    typedef struct packed {
        logic signed [20:0] l_drive;
        logic signed [20:0] r_drive;
        logic               done;
        dpdc_pkg::corr_t    corr;
    } drive_word_t;

    drive_word_t drive_q[$];
    drive_word_t want;

    // register shadow
    longint tgt_dist, tgt_head;
    longint d_kp, d_ki, d_kd, h_kp, h_ki, h_kd;

    // loop state
    longint chk_err, prev_derr, dsum, prev_herr, hsum;
    logic   finished;

    // per-tick scratch
    longint pos, d_err, d_der, h_err, h_der, lat, turn;
    logic   go;
    int     words_out;

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    task automatic report_fault(input string msg);
        $display("drive check: %s", msg);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_dist  = 0;
            tgt_head  = 0;
            d_kp      = 786;
            d_ki      = 131;
            d_kd      = 786;
            h_kp      = 1966;
            h_ki      = 1311;
            h_kd      = 655;
            chk_err   = 0;
            prev_derr = 0;
            dsum      = 0;
            prev_herr = 0;
            hsum      = 0;
            finished  = 1'b0;
            words_out = 0;
            fails     = 0;
            drive_q.delete();
            pending <= 0;
        end
        else
        begin
            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dpdc_pkg::REG_TARGET_DIST: tgt_dist = longint'(signed'(cfg_data));
                    dpdc_pkg::REG_TARGET_HEAD: tgt_head = longint'(signed'(cfg_data));
                    dpdc_pkg::REG_DIST_KP:     d_kp = longint'(cfg_data[15:0]);
                    dpdc_pkg::REG_DIST_KI:     d_ki = longint'(cfg_data[15:0]);
                    dpdc_pkg::REG_DIST_KD:     d_kd = longint'(cfg_data[15:0]);
                    dpdc_pkg::REG_HEAD_KP:     h_kp = longint'(cfg_data[15:0]);
                    dpdc_pkg::REG_HEAD_KI:     h_ki = longint'(cfg_data[15:0]);
                    dpdc_pkg::REG_HEAD_KD:     h_kd = longint'(cfg_data[15:0]);
                    default: ;
                endcase
            end

            // result word against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                begin
                    report_fault($sformatf("result word %0d with nothing expected", words_out));
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (left_drive !== want.l_drive)
                        report_fault($sformatf("word %0d: left_drive %0d, expected %0d",
                                               words_out, left_drive, want.l_drive));
                    if (right_drive !== want.r_drive)
                        report_fault($sformatf("word %0d: right_drive %0d, expected %0d",
                                               words_out, right_drive, want.r_drive));
                    if (done_res !== want.done)
                        report_fault($sformatf("word %0d: done_res %0b, expected %0b",
                                               words_out, done_res, want.done));
                    if (correction !== want.corr)
                        report_fault($sformatf("word %0d: correction %0d, expected %0d",
                                               words_out, correction, want.corr));
                end
                words_out++;
            end

            // tick word: advance the loop state and queue the expected drive word
            if (in_valid && !in_stall)
            begin
                if (restart)
                begin
                    chk_err   = tgt_dist;
                    prev_derr = 0;
                    dsum      = 0;
                    prev_herr = 0;
                    hsum      = 0;
                    finished  = 1'b0;
                end
                go = !finished && ((chk_err > STOP_TOL && tgt_dist > 0) ||
                                   (chk_err < -STOP_TOL && tgt_dist < 0));
                want.l_drive = '0;
                want.r_drive = '0;
                want.corr    = dpdc_pkg::CORR_NONE;
                if (go)
                begin
                    // mean wheel angle to cm, rounded
                    pos   = ((longint'(left_angle) + longint'(right_angle)) * DEG_TO_CM
                             + POS_BIAS) >>> 33;
                    d_err = clip(tgt_dist - pos, ERR_MIN, ERR_MAX);
                    d_der = d_err - prev_derr;
                    dsum  = clip(dsum + d_err, SUM_MIN, SUM_MAX);
                    lat   = ((d_err * d_kp) >>> 16) + ((d_der * d_kd) >>> 16)
                            + ((dsum * d_ki) >>> 16);
                    h_err = clip(longint'(heading) - tgt_head, ERR_MIN, ERR_MAX);
                    h_der = h_err - prev_herr;
                    hsum  = clip(hsum + h_err, SUM_MIN, SUM_MAX);
                    turn  = ((h_err * h_kp) >>> 16) + ((h_der * h_kd) >>> 16)
                            + ((hsum * h_ki) >>> 16);
                    want.l_drive = 21'(clip(lat - turn, -DRIVE_MAX, DRIVE_MAX));
                    want.r_drive = 21'(clip(lat + turn, -DRIVE_MAX, DRIVE_MAX));
                    chk_err   = d_err;
                    prev_derr = d_err;
                    prev_herr = h_err;
                end
                else
                begin
                    // stopped: zero drive, turn hint from this tick's heading
                    finished = 1'b1;
                    if (longint'(heading) > CORR_MARGIN)
                        want.corr = dpdc_pkg::CORR_CCW;
                    else if (longint'(heading) < -CORR_MARGIN)
                        want.corr = dpdc_pkg::CORR_CW;
                end
                want.done = finished;
                drive_q.push_back(want);
            end

            pending <= drive_q.size();
        end
    end

endmodule

FILE: test/dual_pid_drive_controller_test.sv
// Drive controller testbench top: stimulus, idling, watchdog and verdict
module dual_pid_drive_controller_test;

    localparam int     IDLE_LIMIT   = 2000;
    localparam int     TAIL_CYCLES  = 20;
    localparam int     RANDOM_TICKS = 1100;
    localparam int     PHASES       = 3;
    // cm per degree of wheel rotation, Q0.32
    localparam longint WHEEL_SCALE  = 64'sd511704715;
    // heading spreads, Q16.16 degrees
    localparam int     HEAD_RUN     = 983040;
    localparam int     HEAD_STOP    = 655360;
    localparam int     HEAD_TARGET  = 1310720;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               restart     = 1'b0;
    logic signed [31:0] left_angle  = '0;
    logic signed [31:0] right_angle = '0;
    logic signed [31:0] heading     = '0;
    logic               out_stall   = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic [2:0]         cfg_index   = '0;
    logic [31:0]        cfg_data    = '0;
    logic               in_stall;
    logic               out_valid;
    logic signed [20:0] left_drive;
    logic signed [20:0] right_drive;
    logic               done_res;
    logic [1:0]         correction;
    logic               cfg_ready;
    int                 fails;
    int                 pending;

    int tx_idle_pct  = 10;
    int rx_stall_pct = 53;
    int ticks_sent   = 0;
    int idle_cycles  = 0;

    dual_pid_drive_controller u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .left_angle  (left_angle),
        .right_angle (right_angle),
        .heading     (heading),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .done_res    (done_res),
        .correction  (correction),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    dual_pid_drive_controller_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .left_angle  (left_angle),
        .right_angle (right_angle),
        .heading     (heading),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .done_res    (done_res),
        .correction  (correction),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fails       (fails),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    // result side back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int spread(input int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 4000));
            1: return 16'($urandom_range(0, 1000));
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // heading target mostly zero, gains with junk in the unused upper half
    function automatic logic [31:0] reg_value(input logic [2:0] idx);
        if (idx == dpdc_pkg::REG_TARGET_HEAD)
            return ($urandom_range(0, 2) == 0) ? 32'(spread(HEAD_TARGET)) : 32'd0;
        return {16'($urandom), pick_gain()};
    endfunction

    // one register write; cfg_valid is left high for the caller to drop
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // one tick word with random sender idling ahead of it
    task automatic send_tick(input logic rs, input logic signed [31:0] la,
                             input logic signed [31:0] ra, input logic signed [31:0] hd);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        in_valid    <= 1'b1;
        restart     <= rs;
        left_angle  <= la;
        right_angle <= ra;
        heading     <= hd;
        do @(posedge clk); while (in_stall);
        ticks_sent++;
    endtask

    // hold the sender until every expected result word is out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic retune();
        logic [2:0] idx;
        idx = 3'($urandom_range(dpdc_pkg::REG_TARGET_HEAD, dpdc_pkg::REG_HEAD_KD));
        drain();
        write_reg(idx, reg_value(idx));
        cfg_valid <= 1'b0;
    endtask

    // a move: restart, wheels ramping toward the target, then a few stopped ticks
    task automatic run_move();
        longint move_dist, wheel, mag, step_pos, jitter;
        int     n_steps, n_run;
        move_dist = longint'($urandom_range(19661, 1 << 26));
        if ($urandom_range(0, 3) == 0)
            move_dist = longint'($urandom_range(19661, 400000));
        if ($urandom_range(0, 1))
            move_dist = -move_dist;
        wheel = (move_dist <<< 32) / WHEEL_SCALE;
        mag   = (wheel < 0) ? -wheel : wheel;
        drain();
        write_reg(dpdc_pkg::REG_TARGET_DIST, 32'(move_dist));
        cfg_valid <= 1'b0;
        n_steps = $urandom_range(3, 15);
        n_run   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n_steps) : n_steps;
        send_tick(1'b1, '0, '0, spread(HEAD_RUN));
        for (int k = 1; k <= n_run; k++)
        begin
            if ($urandom_range(0, 99) < 4)
                retune();
            step_pos = wheel * k / n_steps;
            jitter   = spread(int'(mag / 40) + 1);
            send_tick(1'b0, 32'(step_pos + jitter), 32'(step_pos - jitter), spread(HEAD_RUN));
        end
        // cut-short moves skip the overshoot and restart straight away
        if (n_run == n_steps)
        begin
            repeat ($urandom_range(1, 3))
            begin
                step_pos = wheel + wheel / longint'($urandom_range(20, 2000));
                send_tick(1'b0, 32'(step_pos), 32'(step_pos), spread(HEAD_STOP));
            end
        end
    endtask

    initial
    begin
        int directed_end;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // no restart since reset: every tick is stopped, correction from heading
        send_tick(1'b0, '0, '0, 32'sh7FFF_FFFF);
        send_tick(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
        send_tick(1'b0, '0, '0, 196608);
        send_tick(1'b0, '0, '0, 196609);
        send_tick(1'b0, '0, '0, -196608);
        send_tick(1'b0, '0, '0, -196609);
        // zero target stops at once
        send_tick(1'b1, 1000, 1000, '0);

        // largest target and gains, wheels and heading at both ends
        drain();
        write_reg(dpdc_pkg::REG_TARGET_DIST, 32'h7FFF_FFFF);
        write_reg(dpdc_pkg::REG_TARGET_HEAD, 32'h8000_0000);
        for (int idx = dpdc_pkg::REG_DIST_KP; idx <= dpdc_pkg::REG_HEAD_KD; idx++)
            write_reg(3'(idx), 32'h0000_FFFF);
        cfg_valid <= 1'b0;
        send_tick(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_tick(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_tick(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, '0);

        // most negative target, zero gains
        drain();
        write_reg(dpdc_pkg::REG_TARGET_DIST, 32'h8000_0000);
        write_reg(dpdc_pkg::REG_TARGET_HEAD, 32'h7FFF_FFFF);
        for (int idx = dpdc_pkg::REG_DIST_KP; idx <= dpdc_pkg::REG_HEAD_KD; idx++)
            write_reg(3'(idx), 32'h0000_0000);
        cfg_valid <= 1'b0;
        send_tick(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_tick(1'b0, '0, '0, '0);

        // gains changed between two ticks of the same move
        drain();
        write_reg(dpdc_pkg::REG_DIST_KP, 32'h0000_FFFF);
        write_reg(dpdc_pkg::REG_HEAD_KI, 32'h0000_FFFF);
        cfg_valid <= 1'b0;
        send_tick(1'b0, 1 << 20, -(1 << 20), 123456);

        // stop band edge: one LSB outside, then exactly on the band
        drain();
        write_reg(dpdc_pkg::REG_TARGET_DIST, 32'd19661);
        cfg_valid <= 1'b0;
        send_tick(1'b1, '0, '0, '0);
        send_tick(1'b0, 8, 8, '0);
        send_tick(1'b0, 8, 8, 300000);
        drain();
        write_reg(dpdc_pkg::REG_TARGET_DIST, -32'sd19661);
        cfg_valid <= 1'b0;
        send_tick(1'b1, '0, '0, '0);
        send_tick(1'b0, -8, -8, '0);
        send_tick(1'b0, -8, -8, -300000);
        drain();
        write_reg(dpdc_pkg::REG_TARGET_DIST, 32'd19660);
        cfg_valid <= 1'b0;
        send_tick(1'b1, '0, '0, '0);

        // random moves and noise, one idling pattern per phase
        directed_end = ticks_sent;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            tx_idle_pct  = (ph == 0) ? 10 : ((ph == 1) ? 53 : 0);
            rx_stall_pct = (ph == 0) ? 53 : ((ph == 1) ? 10 : 0);
            drain();
            for (int idx = dpdc_pkg::REG_TARGET_HEAD; idx <= dpdc_pkg::REG_HEAD_KD; idx++)
                write_reg(3'(idx), reg_value(3'(idx)));
            cfg_valid <= 1'b0;
            while (ticks_sent < directed_end + (ph + 1) * RANDOM_TICKS / PHASES)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 4))
                        send_tick(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
                end
                else
                begin
                    run_move();
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
